// ----- design/rbcs_pkg.sv -----
// rbcs_pkg: constants, codes and item types for the redundant block checksum select
// depends on nothing
`timescale 1ns / 1ps
package rbcs_pkg;

    localparam int BLOCK_LEN   = 130;
    localparam int MAX_COPIES  = 8;
    localparam int STORE_DEPTH = BLOCK_LEN * MAX_COPIES;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int POS_W       = 8;
    localparam int COPY_W      = 3;
    localparam int CNT_W       = 4;

    localparam logic [POS_W-1:0] LAST_POS      = POS_W'(BLOCK_LEN - 1);
    localparam logic [CNT_W-1:0] CNT_RESET     = CNT_W'(2);
    localparam logic [CNT_W-1:0] CNT_MAX       = CNT_W'(MAX_COPIES);

    localparam logic OP_PUSH     = 1'b0;
    localparam logic OP_PULL     = 1'b1;
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_DATA   = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic              kind;
        logic [7:0]        out_byte;
        logic              last_byte;
        logic [7:0]        block_number;
        logic [COPY_W-1:0] chosen_copy;
        logic              sum_found;
        logic              mismatch;
    } t_out;

    typedef struct packed {
        logic push;
        logic pull;
        logic load_byte;
    } t_cmd;

    typedef struct packed {
        logic draining;
        logic block_end;
    } t_stat;

endpackage

// ----- design/redundant_block_checksum_select.sv -----
// redundant_block_checksum_select: top level, joins controller and datapath
// depends on rbcs_pkg, rbcs_ctrl and rbcs_dp
//
// usage
// - input channel i_in_valid / o_in_ready carries items of t_in: opcode push
//   loads the next byte of the current copy, opcode pull reads the next byte
//   of the chosen copy; a pull while loading or a push while reading is dropped
// - output channel o_out_valid / i_out_ready carries items of t_out: one
//   status item when the last byte of the last copy is pushed, then one data
//   item per pull, last_byte set on the final byte of the block
// - i_cfg_we writes copy_count from i_cfg_wdata at once, reset value 2
// - a push's status item is valid the cycle after accept
// - a pull goes through state S_READ: the copy store has a registered read port,
//   so its byte is loaded into the result in S_READ, and ready is low in S_READ
// - the input is accepted while a result waits only if that result is taken
//   in the same cycle; a stalled receiver holds the result and blocks input
// - synchronous reset returns to the loading phase with copy 0, byte 0; the
//   copy store is not cleared and needs no clearing pass
`timescale 1ns / 1ps
module redundant_block_checksum_select (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [rbcs_pkg::CNT_W-1:0] i_cfg_wdata,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  rbcs_pkg::t_in             i_in_item,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output rbcs_pkg::t_out            o_out_item
);
    import rbcs_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    rbcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_opcode(i_in_item.opcode),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    rbcs_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_item  (i_in_item),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_out_item (o_out_item)
    );
endmodule

// ----- design/rbcs_ram.sv -----
// rbcs_ram: generic single write port, single read port ram with registered read
// depends on nothing
`timescale 1ns / 1ps
module rbcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1040
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- design/rbcs_ctrl.sv -----
// rbcs_ctrl: handshake control and read sequencing
// depends on rbcs_pkg
`timescale 1ns / 1ps
module rbcs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_opcode,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  rbcs_pkg::t_stat i_stat,
    output rbcs_pkg::t_cmd  o_cmd
);
    import rbcs_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic w_accept;
    logic w_status;

    assign o_in_ready = r_state == S_IDLE && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd.push      = w_accept && !i_stat.draining && i_in_opcode == OP_PUSH;
        o_cmd.pull      = w_accept && i_stat.draining && i_in_opcode == OP_PULL;
        o_cmd.load_byte = r_state == S_READ;
    end

    assign w_status = o_cmd.push && i_stat.block_end;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_status) begin
                    n_out_valid = 1'b1;
                end
                if (o_cmd.pull) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_read_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |-> !r_out_valid)
        else $error("output register busy during ram read");
    a_pull_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.pull |=> r_state == S_READ)
        else $error("pull did not start a ram read");
    a_read_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |=> r_out_valid)
        else $error("ram read did not produce a result");
    a_status_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status |=> r_out_valid)
        else $error("block end did not produce a status result");
endmodule

// ----- design/rbcs_dp.sv -----
// rbcs_dp: copy store, checksum and selection datapath, result register
// depends on rbcs_pkg and rbcs_ram
`timescale 1ns / 1ps
module rbcs_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [rbcs_pkg::CNT_W-1:0] i_cfg_wdata,
    input  rbcs_pkg::t_in             i_in_item,
    input  rbcs_pkg::t_cmd            i_cmd,
    output rbcs_pkg::t_stat           o_stat,
    output rbcs_pkg::t_out            o_out_item
);
    import rbcs_pkg::*;

    logic [CNT_W-1:0]  r_copy_count;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [COPY_W-1:0] r_ci, n_ci;
    logic [7:0]        r_sum, n_sum;
    logic [7:0]        r_first, n_first;
    logic              r_found, n_found;
    logic              r_mm, n_mm;
    logic              r_cm, n_cm;
    logic [COPY_W-1:0] r_sel, n_sel;
    logic [POS_W-1:0]  r_rp, n_rp;
    logic              r_draining, n_draining;
    logic [ADDR_W-1:0] r_wr_addr, n_wr_addr;
    logic [ADDR_W-1:0] r_rd_addr, n_rd_addr;
    t_out              r_out;
    logic [CNT_W-1:0]  w_eff;
    logic [CNT_W-1:0]  w_ci_next;
    logic [7:0]        w_rdata;
    logic [7:0]        w_b;

    assign w_b       = i_in_item.data_byte;
    assign w_ci_next = CNT_W'(r_ci) + CNT_W'(1);

    always_comb begin
        w_eff = r_copy_count;
        if (r_copy_count == '0) begin
            w_eff = CNT_W'(1);
        end else if (r_copy_count > CNT_MAX) begin
            w_eff = CNT_MAX;
        end
    end

    always_comb begin
        o_stat.draining  = r_draining;
        o_stat.block_end = r_pos == LAST_POS && w_ci_next >= w_eff;
    end

    always_comb begin
        n_pos      = r_pos;
        n_ci       = r_ci;
        n_sum      = r_sum;
        n_first    = r_first;
        n_found    = r_found;
        n_mm       = r_mm;
        n_cm       = r_cm;
        n_sel      = r_sel;
        n_rp       = r_rp;
        n_draining = r_draining;
        n_wr_addr  = r_wr_addr;
        n_rd_addr  = r_rd_addr;
        if (i_cmd.push) begin
            n_wr_addr = r_wr_addr + ADDR_W'(1);
            if (r_pos == '0) begin
                n_sum = '0;
                n_cm  = 1'b0;
                if (r_ci == '0) begin
                    n_first = w_b;
                end else if (w_b != r_first) begin
                    n_cm = 1'b1;
                    n_mm = 1'b1;
                end
            end else if (r_pos != LAST_POS) begin
                n_sum = r_sum + w_b;
            end
            if (r_pos == LAST_POS) begin
                if (!r_found && !r_cm && r_sum == w_b) begin
                    n_found = 1'b1;
                    n_sel   = r_ci;
                end
                n_pos = '0;
                if (o_stat.block_end) begin
                    if (!n_found) begin
                        n_sel = '0;
                    end
                    n_draining = 1'b1;
                    n_rp       = '0;
                    n_wr_addr  = '0;
                    n_rd_addr  = ADDR_W'(n_sel) * ADDR_W'(BLOCK_LEN);
                end else begin
                    n_ci = r_ci + COPY_W'(1);
                end
            end else begin
                n_pos = r_pos + POS_W'(1);
            end
        end else if (i_cmd.pull) begin
            if (r_rp == LAST_POS) begin
                n_pos      = '0;
                n_ci       = '0;
                n_sum      = '0;
                n_first    = '0;
                n_found    = 1'b0;
                n_mm       = 1'b0;
                n_cm       = 1'b0;
                n_sel      = '0;
                n_rp       = '0;
                n_draining = 1'b0;
                n_wr_addr  = '0;
            end else begin
                n_rp      = r_rp + POS_W'(1);
                n_rd_addr = r_rd_addr + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_copy_count <= CNT_RESET;
            r_pos        <= '0;
            r_ci         <= '0;
            r_sum        <= '0;
            r_first      <= '0;
            r_found      <= 1'b0;
            r_mm         <= 1'b0;
            r_cm         <= 1'b0;
            r_sel        <= '0;
            r_rp         <= '0;
            r_draining   <= 1'b0;
            r_wr_addr    <= '0;
            r_rd_addr    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_copy_count <= i_cfg_wdata;
            end
            r_pos      <= n_pos;
            r_ci       <= n_ci;
            r_sum      <= n_sum;
            r_first    <= n_first;
            r_found    <= n_found;
            r_mm       <= n_mm;
            r_cm       <= n_cm;
            r_sel      <= n_sel;
            r_rp       <= n_rp;
            r_draining <= n_draining;
            r_wr_addr  <= n_wr_addr;
            r_rd_addr  <= n_rd_addr;
        end
    end

    // result payload, byte of a data item is loaded from the ram read port in S_READ
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && o_stat.block_end) begin
            r_out.kind         <= KIND_STATUS;
            r_out.out_byte     <= '0;
            r_out.last_byte    <= 1'b0;
            r_out.block_number <= n_first;
            r_out.chosen_copy  <= n_sel;
            r_out.sum_found    <= n_found;
            r_out.mismatch     <= n_mm;
        end else if (i_cmd.pull) begin
            r_out.kind         <= KIND_DATA;
            r_out.out_byte     <= '0;
            r_out.last_byte    <= r_rp == LAST_POS;
            r_out.block_number <= r_first;
            r_out.chosen_copy  <= r_sel;
            r_out.sum_found    <= r_found;
            r_out.mismatch     <= r_mm;
        end else if (i_cmd.load_byte) begin
            r_out.out_byte <= w_rdata;
        end
    end

    assign o_out_item = r_out;

    rbcs_ram #(
        .WIDTH(8),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (i_cmd.push),
        .i_waddr(r_wr_addr),
        .i_wdata(w_b),
        .i_re   (i_cmd.pull),
        .i_raddr(r_rd_addr),
        .o_rdata(w_rdata)
    );
endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: self-checking bench for redundant_block_checksum_select
// depends on rbcs_pkg and the redundant_block_checksum_select rtl
module tb_top;
    import rbcs_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int SETTLE_CYCLES = 6;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_we    = 1'b0;
    logic [CNT_W-1:0] i_cfg_wdata = '0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_ready;
    t_in              i_in_item   = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    t_out             o_out_item;

    bit   send_idle_on = 1'b1;
    bit   recv_idle_on = 1'b1;
    int   noise_pct    = 0;
    int   rx_hold_req  = 0;
    int   bad_count    = 0;
    t_out tape_results[$];

    // mirror of the block state
    logic [CNT_W-1:0]  copies_cfg;
    logic [POS_W-1:0]  load_pos;
    logic [COPY_W-1:0] load_copy;
    logic [7:0]        load_sum;
    logic [7:0]        head_number;
    logic              any_good;
    logic              any_clash;
    logic              this_clash;
    logic [COPY_W-1:0] pick;
    logic [POS_W-1:0]  read_pos;
    logic              draining;
    logic [7:0]        copy_mem [STORE_DEPTH];

    redundant_block_checksum_select i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic int copies_in_use();
        int c;
        c = int'(copies_cfg);
        if (c == 0) c = 1;
        if (c > MAX_COPIES) c = MAX_COPIES;
        return c;
    endfunction

    function automatic void restart_block();
        load_pos    = '0;
        load_copy   = '0;
        load_sum    = '0;
        head_number = '0;
        any_good    = 1'b0;
        any_clash   = 1'b0;
        this_clash  = 1'b0;
        pick        = '0;
        read_pos    = '0;
        draining    = 1'b0;
    endfunction

    function automatic bit apply_tape_item(input t_in it, output t_out res);
        int at;
        res = '0;
        if (!draining) begin
            if (it.opcode != OP_PUSH) return 1'b0;
            at = int'(load_copy) * BLOCK_LEN + int'(load_pos);
            copy_mem[at] = it.data_byte;
            if (load_pos == 0) begin
                load_sum   = '0;
                this_clash = 1'b0;
                if (load_copy == 0) begin
                    head_number = it.data_byte;
                end else if (it.data_byte != head_number) begin
                    this_clash = 1'b1;
                    any_clash  = 1'b1;
                end
            end else if (load_pos < LAST_POS) begin
                load_sum = load_sum + it.data_byte;
            end
            if (load_pos == LAST_POS) begin
                if (!any_good && !this_clash && load_sum == it.data_byte) begin
                    any_good = 1'b1;
                    pick     = load_copy;
                end
                load_pos = '0;
                if (int'(load_copy) + 1 >= copies_in_use()) begin
                    if (!any_good) pick = '0;
                    draining         = 1'b1;
                    read_pos         = '0;
                    res.kind         = KIND_STATUS;
                    res.block_number = head_number;
                    res.chosen_copy  = pick;
                    res.sum_found    = any_good;
                    res.mismatch     = any_clash;
                    return 1'b1;
                end
                load_copy = load_copy + 1'b1;
                return 1'b0;
            end
            load_pos = load_pos + 1'b1;
            return 1'b0;
        end
        if (it.opcode != OP_PULL) return 1'b0;
        res.kind         = KIND_DATA;
        res.out_byte     = copy_mem[int'(pick) * BLOCK_LEN + int'(read_pos)];
        res.last_byte    = (read_pos == LAST_POS);
        res.block_number = head_number;
        res.chosen_copy  = pick;
        res.sum_found    = any_good;
        res.mismatch     = any_clash;
        if (read_pos == LAST_POS) restart_block();
        else read_pos = read_pos + 1'b1;
        return 1'b1;
    endfunction

    task automatic send_item(input logic op, input logic [7:0] value);
        t_in  it;
        t_out res;
        int   gap;
        it.opcode    = op;
        it.data_byte = value;
        gap = send_idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        if (apply_tape_item(it, res)) tape_results.push_back(res);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (tape_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [CNT_W-1:0] value);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        copies_cfg = value;
    endtask

    // recount_at in 1 to 128 rewrites the copy count before that byte of the copy
    task automatic push_copy(input logic [7:0] number, input bit sum_ok, input int fill,
                             input int recount_at, input logic [CNT_W-1:0] recount_to);
        logic [7:0] total;
        logic [7:0] b;
        total = '0;
        send_item(OP_PUSH, number);
        for (int i = 1; i < BLOCK_LEN - 1; i++) begin
            if (i == recount_at) write_count(recount_to);
            if ($urandom_range(0, 99) < noise_pct) send_item(OP_PULL, 8'($urandom));
            b = (fill < 0) ? 8'($urandom) : 8'(fill);
            total = total + b;
            send_item(OP_PUSH, b);
        end
        send_item(OP_PUSH, sum_ok ? total : total + 8'($urandom_range(1, 255)));
    endtask

    task automatic pull_block();
        for (int i = 0; i < BLOCK_LEN; i++) begin
            if ($urandom_range(0, 99) < noise_pct) send_item(OP_PUSH, 8'($urandom));
            send_item(OP_PULL, 8'($urandom));
        end
    endtask

    // runs at the reset copy count, receiver holds off across the status item
    task automatic test_stalled_receiver();
        noise_pct = 0;
        send_item(OP_PULL, 8'hff);
        push_copy(8'hff, 1'b0, -1, -1, '0);
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        rx_hold_req  = 250;
        push_copy(8'hff, 1'b1, -1, -1, '0);
        pull_block();
        settle();
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
    endtask

    task automatic test_count_limits();
        noise_pct = 4;
        // grow above the limit during the first copy
        push_copy(8'h7f, 1'b0, -1, 10, CNT_W'(15));
        // clashing block number with a good sum
        push_copy(8'h80, 1'b1, -1, -1, '0);
        repeat (MAX_COPIES - 3) push_copy(8'h7f, 1'b0, -1, -1, '0);
        push_copy(8'h7f, 1'b1, -1, -1, '0);
        pull_block();
    endtask

    task automatic test_count_change();
        noise_pct = 3;
        write_count(CNT_W'(4));
        push_copy(8'h44, 1'b0, 0, -1, '0);
        // shrink to zero, below the copy in flight, no good sum
        push_copy(8'h44, 1'b0, 255, 64, CNT_W'(0));
        pull_block();
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t %s expected %0h actual %0h", $time, name, want, got);
            bad_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_out want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (tape_results.size() == 0) begin
                $display("%0t unexpected item expected none actual %h", $time, o_out_item);
                bad_count++;
            end else begin
                want = tape_results.pop_front();
                check_field("kind", want.kind, o_out_item.kind);
                check_field("out_byte", want.out_byte, o_out_item.out_byte);
                check_field("last_byte", want.last_byte, o_out_item.last_byte);
                check_field("block_number", want.block_number, o_out_item.block_number);
                check_field("chosen_copy", want.chosen_copy, o_out_item.chosen_copy);
                check_field("sum_found", want.sum_found, o_out_item.sum_found);
                check_field("mismatch", want.mismatch, o_out_item.mismatch);
            end
        end
    end

    // receiver side, wait drawn per item plus requested long holds
    initial begin : rx_side
        int rx_wait;
        rx_wait = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && i_out_ready)
                rx_wait = recv_idle_on ? $urandom_range(0, 7) : 0;
            if (rx_hold_req > 0) begin
                rx_wait     = rx_wait + rx_hold_req;
                rx_hold_req = 0;
            end
            if (rx_wait > 0) begin
                i_out_ready <= 1'b0;
                rx_wait--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        restart_block();
        copies_cfg = CNT_RESET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_stalled_receiver();
        test_count_limits();
        test_count_change();
        settle();
        if (bad_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("tb_top: errors");
        $finish;
    end

endmodule
